// ===== src/q16alu_pkg.sv =====
// q16alu_pkg: shared types and constants for the Q16.16 fixed-point ALU.
// No dependencies; compile first.
`timescale 1ns / 1ps
package q16alu_pkg;

    localparam int DATA_W = 32;
    localparam int KIND_W = 4;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_REM      = 4'd4,
        OP_NEG      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT   = 4'd9,
        OP_COMPARE  = 4'd10
    } op_t;

endpackage

// ===== src/q16alu_if.sv =====
// q16alu_if: valid/ready channel interfaces for the ALU operand and result words.
// Depends on nothing; compile after q16alu_pkg.
`timescale 1ns / 1ps
interface q16alu_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, kind, operand_a, operand_b, input ready);
    modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface q16alu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               is_equal;
    logic               is_less;
    logic               is_greater;
    logic               divide_by_zero;

    modport source (output valid, result_value, is_equal, is_less, is_greater,
                    divide_by_zero, input ready);
    modport sink   (input valid, result_value, is_equal, is_less, is_greater,
                    divide_by_zero, output ready);
endinterface

// ===== src/q16_16_fixed_point_alu.sv =====
// q16_16_fixed_point_alu: pipelined signed fixed-point ALU (top level).
// Depends on q16alu_pkg and the channel interfaces in q16alu_if.sv.
//
// Usage:
//   in_ch carries one operation word per handshake: kind, operand_a, operand_b.
//   out_ch returns exactly one result word per operation, in order: result_value
//   and the is_equal / is_less / is_greater / divide_by_zero flags.
//   Throughput is one word per cycle while the receiver does not stall. A word
//   passes the input register, stage 1, the divider stages and the output
//   register in turn. The divider is a restoring divider with one quotient
//   bit per pipeline stage over the 32 + FRACTION_BITS bit numerator. Every
//   operation, divide or not, flows through the same stages, so results leave
//   in order.
//   The multiply is a single 32x32 signed product, registered before the shift.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ch.ready drops; nothing is dropped or repeated. Words keep entering
//   while the output register is empty or being drained in the same cycle.
//   Reset clears every stage valid bit; payload registers are not reset.
//   Divide or remainder by zero returns 0 with divide_by_zero set.
`timescale 1ns / 1ps
module q16_16_fixed_point_alu #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    q16alu_in_if.sink           in_ch,
    q16alu_out_if.source        out_ch
);
    import q16alu_pkg::*;

    localparam int NW = DATA_W + FRACTION_BITS;   // divider numerator width

    typedef struct packed {
        op_t                 kind;
        logic [DATA_W-1:0]   res;
        logic                eq;
        logic                lt;
        logic                gt;
        logic                dz;
        logic                negq;
        logic                negr;
    } meta_t;

    typedef struct packed {
        logic [DATA_W-1:0]   rem;
        logic [NW-1:0]       num;
        logic [DATA_W-1:0]   quo;
        logic [DATA_W-1:0]   den;
    } div_t;

    // global advance: whole pipe moves when the output slot is free or being drained
    logic advance;

    // input register
    logic                     in_valid_reg;
    logic [KIND_W-1:0]        kind_reg;
    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] b_reg;

    // stage 1 outputs (index 0) and divider stage outputs (index 1 to NW)
    logic                     v_reg  [NW+1];
    meta_t                    m_reg  [NW+1];
    div_t                     d_reg  [NW+1];
    logic [2*DATA_W-1:0]      prod_reg;

    // output register
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_res_reg;
    logic                     out_eq_reg;
    logic                     out_lt_reg;
    logic                     out_gt_reg;
    logic                     out_dz_reg;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg <= in_ch.kind;
            a_reg    <= in_ch.operand_a;
            b_reg    <= in_ch.operand_b;
        end
    end

    // stage 1: decode, simple results, product, divider setup
    meta_t               m1_next;
    div_t                d1_next;
    logic [DATA_W-1:0]   mag_a;
    logic [DATA_W-1:0]   mag_b;
    logic [DATA_W-1:0]   one_fx;
    op_t                 op;

    always_comb
    begin
        op     = op_t'(kind_reg);
        mag_a  = a_reg[DATA_W-1] ? DATA_W'(-a_reg) : DATA_W'(a_reg);
        mag_b  = b_reg[DATA_W-1] ? DATA_W'(-b_reg) : DATA_W'(b_reg);
        one_fx = DATA_W'(1) << FRACTION_BITS;

        m1_next.kind = op;
        m1_next.eq   = (a_reg == b_reg);
        m1_next.lt   = (a_reg < b_reg);
        m1_next.gt   = (a_reg > b_reg);
        m1_next.dz   = ((op == OP_DIV) || (op == OP_REM)) && (b_reg == '0);
        m1_next.negq = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
        m1_next.negr = a_reg[DATA_W-1];
        unique case (op)
            OP_ADD:      m1_next.res = DATA_W'(a_reg + b_reg);
            OP_SUB:      m1_next.res = DATA_W'(a_reg - b_reg);
            OP_NEG:      m1_next.res = DATA_W'(-a_reg);
            OP_INC:      m1_next.res = DATA_W'(a_reg) + one_fx;
            OP_DEC:      m1_next.res = DATA_W'(a_reg) - one_fx;
            OP_FROM_INT: m1_next.res = DATA_W'(a_reg) << FRACTION_BITS;
            OP_TO_INT:   m1_next.res = DATA_W'(a_reg >>> FRACTION_BITS);
            default:     m1_next.res = '0;
        endcase

        d1_next.rem = '0;
        d1_next.quo = '0;
        d1_next.den = mag_b;
        d1_next.num = (op == OP_REM) ? NW'(mag_a) : {mag_a, {FRACTION_BITS{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            v_reg[0] <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_reg[0] <= m1_next;
            d_reg[0] <= d1_next;
            prod_reg <= (2*DATA_W)'(a_reg * b_reg);
        end
    end

    // divider stages: one quotient bit each; the multiply result is folded
    // into the carried result at the first of them
    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_div
            logic [DATA_W:0] trial;
            logic            ge;
            div_t            d_next;
            meta_t           m_next;

            always_comb
            begin
                trial      = {d_reg[k].rem, d_reg[k].num[NW-1]};
                ge         = trial >= {1'b0, d_reg[k].den};
                d_next     = d_reg[k];
                d_next.num = {d_reg[k].num[NW-2:0], 1'b0};
                d_next.quo = {d_reg[k].quo[DATA_W-2:0], ge};
                d_next.rem = ge ? DATA_W'(trial - {1'b0, d_reg[k].den})
                                : trial[DATA_W-1:0];
                m_next     = m_reg[k];
                if (k == 0 && m_reg[k].kind == OP_MUL)
                begin
                    m_next.res = prod_reg[FRACTION_BITS+DATA_W-1:FRACTION_BITS];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k+1] <= 1'b0;
                end
                else if (advance)
                begin
                    v_reg[k+1] <= v_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    m_reg[k+1] <= m_next;
                    d_reg[k+1] <= d_next;
                end
            end
        end
    endgenerate

    // final stage: sign-correct quotient / remainder, pick result
    logic [DATA_W-1:0] res_next;
    meta_t             mf;
    div_t              df;

    always_comb
    begin
        mf = m_reg[NW];
        df = d_reg[NW];
        if (mf.dz)
        begin
            res_next = '0;
        end
        else if (mf.kind == OP_DIV)
        begin
            res_next = mf.negq ? DATA_W'(-df.quo) : df.quo;
        end
        else if (mf.kind == OP_REM)
        begin
            res_next = mf.negr ? DATA_W'(-df.rem) : df.rem;
        end
        else
        begin
            res_next = mf.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= v_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
            out_eq_reg  <= mf.eq;
            out_lt_reg  <= mf.lt;
            out_gt_reg  <= mf.gt;
            out_dz_reg  <= mf.dz;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.result_value   = out_res_reg;
    assign out_ch.is_equal       = out_eq_reg;
    assign out_ch.is_less        = out_lt_reg;
    assign out_ch.is_greater     = out_gt_reg;
    assign out_ch.divide_by_zero = out_dz_reg;

    // a divide by zero always reports a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_dz_reg |-> out_res_reg == '0)
        else $error("divide by zero with nonzero result");

    // exactly one ordering flag per result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot({out_eq_reg, out_lt_reg, out_gt_reg}))
        else $error("comparison flags not one-hot");

    // a stall freezes the input, stage 1 and last divider stage valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(v_reg[NW]) && $stable(v_reg[0]) && $stable(in_valid_reg))
        else $error("pipeline moved during stall");

    // the last divider stage feeds the output register when the pipe advances
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && v_reg[NW] |=> out_valid_reg)
        else $error("result lost at output register");

endmodule
